// ===== design/slot_execution_budget_monitor_macros.svh =====
// Assertion macros for the slot execution budget monitor.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SLOT_EXECUTION_BUDGET_MONITOR_MACROS_SVH
`define SLOT_EXECUTION_BUDGET_MONITOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off while reset is high.
`define SEBM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sebm: same-cycle check failed");
// Next-cycle implication, held off while reset is high.
`define SEBM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sebm: next-cycle check failed");
`else
`define SEBM_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define SEBM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== design/sebm_pkg.sv =====
// Shared types and constants for the slot execution budget monitor.
// No dependencies; used by sebm_slot_update and the top level.
package sebm_pkg;

   localparam int SLOT_COUNT = 4;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int BUDGET_REGS = 4;

   localparam logic [6:0]  ERROR_LIMIT    = 7'd100;
   localparam logic [3:0]  OVERRUN_LIMIT  = 4'd10;
   localparam logic [31:0] DEFAULT_BUDGET_RESET = 32'd10000;

   // operation codes
   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_ENABLE_MASK    = 3'd0;
   localparam logic [2:0] CSR_DEFAULT_BUDGET = 3'd1;
   localparam logic [2:0] CSR_BUDGET_SLOT0   = 3'd2;
   localparam logic [2:0] CSR_BUDGET_SLOT1   = 3'd3;
   localparam logic [2:0] CSR_BUDGET_SLOT2   = 3'd4;
   localparam logic [2:0] CSR_BUDGET_SLOT3   = 3'd5;

   typedef enum logic [2:0] {
      ST_SKIPPED     = 3'd0,
      ST_OK          = 3'd1,
      ST_OVER_BUDGET = 3'd2,
      ST_STOP_BUDGET = 3'd3,
      ST_CALL_ERROR  = 3'd4,
      ST_STOP_ERRORS = 3'd5,
      ST_CLEARED     = 3'd6
   } status_type;

   typedef struct packed {
      logic        operation;
      logic [1:0]  slot;
      logic        call_failed;
      logic [31:0] exec_time_us;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        forward_events;
      logic [31:0] frames_done;
      logic [6:0]  errors_seen;
      logic [3:0]  overrun_count;
      logic [31:0] worst_time;
      logic [31:0] time_sum;
   } rsp_type;

   typedef struct packed {
      logic [31:0] frame_counter;
      logic [6:0]  error_counter;
      logic [3:0]  overrun_counter;
      logic [31:0] longest_time;
      logic [31:0] total_time;
      logic        slot_faulted;
   } record_type;

   typedef struct packed {
      logic       write;
      record_type rec;
   } update_type;

endpackage

// ===== design/slot_execution_budget_monitor.sv =====
// Slot execution budget monitor: an accepted transaction is held in the request
// register, and its result strobe comes from the result register after it.
// Throughput is one transaction per cycle, set by a single read-modify-write
// of the slot record between the request register and the result register.
// Reset is synchronous: records clear, registers take their reset values,
// and busy is high only while reset is held. The receiver cannot stall.
// Depends on sebm_pkg, sebm_slot_update and the assertion macro header.
`include "slot_execution_budget_monitor_macros.svh"

module slot_execution_budget_monitor (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sebm_pkg::req_type req_item,
   output logic              rsp_valid,
   output sebm_pkg::rsp_type rsp_item,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   // configuration registers
   logic [3:0]  enable_mask_ff;
   logic [31:0] default_budget_ff;
   logic [31:0] slot_budget_ff [sebm_pkg::BUDGET_REGS];

   // request stage
   logic              item_valid_ff;
   sebm_pkg::req_type item_ff;

   // per-slot records
   sebm_pkg::record_type rec_ff [sebm_pkg::SLOT_COUNT];

   // result stage
   logic              rsp_valid_ff;
   sebm_pkg::rsp_type rsp_ff;
   sebm_pkg::rsp_type rsp_in;

   logic                          accept;
   logic                          in_range;
   logic [sebm_pkg::SLOT_IDX_W-1:0] slot_idx;
   sebm_pkg::record_type          cur_rec;
   sebm_pkg::update_type          upd;

   // hold off new transactions only while reset is applied
   assign busy   = reset;
   assign accept = start && !busy;

   // ---------------------------------------------------------------
   // Configuration writes; indexes beyond the list are dropped.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff    <= '0;
         default_budget_ff <= sebm_pkg::DEFAULT_BUDGET_RESET;
         for (int i = 0; i < sebm_pkg::BUDGET_REGS; i++) begin
            slot_budget_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            sebm_pkg::CSR_ENABLE_MASK:    enable_mask_ff    <= csr_wdata[3:0];
            sebm_pkg::CSR_DEFAULT_BUDGET: default_budget_ff <= csr_wdata;
            sebm_pkg::CSR_BUDGET_SLOT0:   slot_budget_ff[0] <= csr_wdata;
            sebm_pkg::CSR_BUDGET_SLOT1:   slot_budget_ff[1] <= csr_wdata;
            sebm_pkg::CSR_BUDGET_SLOT2:   slot_budget_ff[2] <= csr_wdata;
            sebm_pkg::CSR_BUDGET_SLOT3:   slot_budget_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Request register: capture every accepted transaction.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   // ---------------------------------------------------------------
   // Record select. The record written at the previous edge is already
   // in place, so back-to-back reports on one slot need no forwarding.
   // ---------------------------------------------------------------
   assign in_range = (32'(item_ff.slot) < sebm_pkg::SLOT_COUNT);
   assign slot_idx = sebm_pkg::SLOT_IDX_W'(item_ff.slot);

   always_comb begin
      if (in_range) begin
         cur_rec = rec_ff[slot_idx];
      end else begin
         cur_rec = '0;
      end
   end

   sebm_slot_update u_update (
      .item           (item_ff),
      .in_range       (in_range),
      .enabled        (enable_mask_ff[item_ff.slot]),
      .cur_rec        (cur_rec),
      .slot_budget    (slot_budget_ff[item_ff.slot]),
      .default_budget (default_budget_ff),
      .upd            (upd),
      .rsp            (rsp_in)
   );

   // write back the slot record
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sebm_pkg::SLOT_COUNT; i++) begin
            rec_ff[i] <= '0;
         end
      end else if (item_valid_ff && upd.write) begin
         rec_ff[slot_idx] <= upd.rec;
      end
   end

   // ---------------------------------------------------------------
   // Result register: one strobe per transaction, never held.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `SEBM_ASSERT_NEXT(a_accept_gives_two_cycle_result, clock, reset, accept, item_valid_ff ##1 rsp_valid)
   `SEBM_ASSERT_IMPLY(a_forward_matches_status, clock, reset, rsp_valid, rsp_item.forward_events == ((rsp_item.status == sebm_pkg::ST_OK) || (rsp_item.status == sebm_pkg::ST_OVER_BUDGET)))
   `SEBM_ASSERT_IMPLY(a_budget_stop_at_limit, clock, reset, rsp_valid && (rsp_item.status == sebm_pkg::ST_STOP_BUDGET), rsp_item.overrun_count == sebm_pkg::OVERRUN_LIMIT)
   `SEBM_ASSERT_IMPLY(a_error_stop_at_limit, clock, reset, rsp_valid && (rsp_item.status == sebm_pkg::ST_STOP_ERRORS), rsp_item.errors_seen == sebm_pkg::ERROR_LIMIT)
   `SEBM_ASSERT_IMPLY(a_clear_empties_record, clock, reset, rsp_valid && (rsp_item.status == sebm_pkg::ST_CLEARED), (rsp_item.frames_done == 32'd0) && (rsp_item.time_sum == 32'd0))

endmodule

// ===== design/sebm_slot_update.sv =====
// Next-record and result logic for one slot report or clear.
// Depends on sebm_pkg.
module sebm_slot_update (
   input  sebm_pkg::req_type    item,
   input  logic                 in_range,
   input  logic                 enabled,
   input  sebm_pkg::record_type cur_rec,
   input  logic [31:0]          slot_budget,
   input  logic [31:0]          default_budget,
   output sebm_pkg::update_type upd,
   output sebm_pkg::rsp_type    rsp
);

   logic [31:0]          eff_budget;
   logic [6:0]           err_inc;
   logic [3:0]           ovr_inc;
   sebm_pkg::record_type nxt;
   sebm_pkg::status_type status;
   logic                 write;

   assign eff_budget = (slot_budget != 32'd0) ? slot_budget : default_budget;
   assign err_inc    = cur_rec.error_counter + 7'd1;
   assign ovr_inc    = cur_rec.overrun_counter + 4'd1;

   always_comb begin
      nxt    = cur_rec;
      status = sebm_pkg::ST_SKIPPED;
      write  = 1'b0;
      if (in_range) begin
         if (item.operation == sebm_pkg::OP_CLEAR) begin
            nxt    = '0;
            status = sebm_pkg::ST_CLEARED;
            write  = 1'b1;
         end else if (enabled && !cur_rec.slot_faulted) begin
            write = 1'b1;
            if (item.call_failed) begin
               if (err_inc >= sebm_pkg::ERROR_LIMIT) begin
                  nxt.error_counter = sebm_pkg::ERROR_LIMIT;
                  nxt.slot_faulted  = 1'b1;
                  status            = sebm_pkg::ST_STOP_ERRORS;
               end else begin
                  nxt.error_counter = err_inc;
                  status            = sebm_pkg::ST_CALL_ERROR;
               end
            end else begin
               nxt.frame_counter = cur_rec.frame_counter + 32'd1;
               nxt.total_time    = cur_rec.total_time + item.exec_time_us;
               if (item.exec_time_us > cur_rec.longest_time) begin
                  nxt.longest_time = item.exec_time_us;
               end
               if (item.exec_time_us > eff_budget) begin
                  if (ovr_inc >= sebm_pkg::OVERRUN_LIMIT) begin
                     nxt.overrun_counter = sebm_pkg::OVERRUN_LIMIT;
                     nxt.slot_faulted    = 1'b1;
                     status              = sebm_pkg::ST_STOP_BUDGET;
                  end else begin
                     nxt.overrun_counter = ovr_inc;
                     status              = sebm_pkg::ST_OVER_BUDGET;
                  end
               end else begin
                  // short frame: forgive earlier overruns
                  if (item.exec_time_us < (eff_budget >> 1)) begin
                     nxt.overrun_counter = 4'd0;
                  end
                  status = sebm_pkg::ST_OK;
               end
            end
         end
      end
   end

   always_comb begin
      upd.write = write;
      upd.rec   = nxt;
      rsp.status         = status;
      rsp.forward_events = (status == sebm_pkg::ST_OK) ||
                           (status == sebm_pkg::ST_OVER_BUDGET);
      if (in_range) begin
         rsp.frames_done   = nxt.frame_counter;
         rsp.errors_seen   = nxt.error_counter;
         rsp.overrun_count = nxt.overrun_counter;
         rsp.worst_time    = nxt.longest_time;
         rsp.time_sum      = nxt.total_time;
      end else begin
         rsp.frames_done   = '0;
         rsp.errors_seen   = '0;
         rsp.overrun_count = '0;
         rsp.worst_time    = '0;
         rsp.time_sum      = '0;
      end
   end

endmodule

// ===== verif/slot_execution_budget_monitor_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for slot_execution_budget_monitor: a directed table, then random
// report and clear traffic across several budget settings, scored against a predictor.
// Depends on sebm_pkg and the monitor RTL only.
module slot_execution_budget_monitor_tb;
   import sebm_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int STALL_LIMIT   = 500;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 116;
   localparam int DRAIN_CYCLES  = 4;

   // indexes past the last budget register; writes there must change nothing
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   // classes of elapsed time, relative to the slot's effective budget
   localparam int TIME_ANY   = 0;
   localparam int TIME_OVER  = 1;
   localparam int TIME_SHORT = 2;

   localparam rsp_type BLANK_RSP   = '0;
   localparam rsp_type CLEARED_RSP = '{ST_CLEARED, 1'b0, 32'd0, 7'd0, 4'd0, 32'd0, 32'd0};

   typedef struct packed {
      logic [3:0]       mask;
      logic [31:0]      fallback;
      logic [0:3][31:0] budgets;
   } budget_setting_type;

   typedef struct packed {
      logic [1:0] setting;
      req_type    item;
      logic       typed;
      rsp_type    want;
   } directed_row_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   req_type     req_item  = '0;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_item;

   // predictor copy of the registers and of the per-slot records
   logic [3:0]  enabled_slots;
   logic [31:0] fallback_budget;
   logic [31:0] slot_budgets [4];
   record_type  slot_records [SLOT_COUNT];

   rsp_type     expected_results [$];
   int          mismatch_count = 0;
   int          stall_cycles   = 0;
   int          phase_sent;

   // Setting 0 is the state after reset and is never written.
   budget_setting_type directed_settings [3] = '{
      '{4'h0, DEFAULT_BUDGET_RESET, '{32'd0, 32'd0, 32'd0, 32'd0}},
      '{4'hF, 32'd10000, '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0}},
      '{4'hF, 32'd0, '{32'd0, 32'h8000_0000, 32'd0, 32'd0}}
   };

   // Expected values are typed in only where they follow at a glance; the rest
   // are left to the predictor.
   directed_row_type directed_rows [19] = '{
      // after reset: every slot disabled, clear still works
      '{2'd0, '{OP_REPORT, 2'd0, 1'b0, 32'd5}, 1'b1, BLANK_RSP},
      '{2'd0, '{OP_CLEAR, 2'd3, 1'b0, 32'd0}, 1'b1, CLEARED_RSP},
      '{2'd0, '{OP_REPORT, 2'd2, 1'b1, 32'hFFFF_FFFF}, 1'b1, BLANK_RSP},
      // slot 0 on the default budget: at, over, and under half of it
      '{2'd1, '{OP_REPORT, 2'd0, 1'b0, 32'd100}, 1'b1,
        '{ST_OK, 1'b1, 32'd1, 7'd0, 4'd0, 32'd100, 32'd100}},
      '{2'd1, '{OP_REPORT, 2'd0, 1'b0, 32'd10000}, 1'b1,
        '{ST_OK, 1'b1, 32'd2, 7'd0, 4'd0, 32'd10000, 32'd10100}},
      '{2'd1, '{OP_REPORT, 2'd0, 1'b0, 32'd10001}, 1'b1,
        '{ST_OVER_BUDGET, 1'b1, 32'd3, 7'd0, 4'd1, 32'd10001, 32'd20101}},
      '{2'd1, '{OP_REPORT, 2'd0, 1'b0, 32'd4999}, 1'b1,
        '{ST_OK, 1'b1, 32'd4, 7'd0, 4'd0, 32'd10001, 32'd25100}},
      '{2'd1, '{OP_REPORT, 2'd0, 1'b0, 32'd5000}, 1'b0, BLANK_RSP},
      // slot 1 with the smallest budget, slot 2 with the largest
      '{2'd1, '{OP_REPORT, 2'd1, 1'b0, 32'd0}, 1'b0, BLANK_RSP},
      '{2'd1, '{OP_REPORT, 2'd1, 1'b0, 32'd2}, 1'b0, BLANK_RSP},
      '{2'd1, '{OP_REPORT, 2'd2, 1'b0, 32'hFFFF_FFFF}, 1'b1,
        '{ST_OK, 1'b1, 32'd1, 7'd0, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
      '{2'd1, '{OP_REPORT, 2'd2, 1'b0, 32'd1}, 1'b0, BLANK_RSP},
      '{2'd1, '{OP_REPORT, 2'd3, 1'b1, 32'd123}, 1'b1,
        '{ST_CALL_ERROR, 1'b0, 32'd0, 7'd1, 4'd0, 32'd0, 32'd0}},
      '{2'd1, '{OP_CLEAR, 2'd1, 1'b0, 32'd0}, 1'b1, CLEARED_RSP},
      '{2'd1, '{OP_CLEAR, 2'd0, 1'b1, 32'hDEAD_BEEF}, 1'b1, CLEARED_RSP},
      // zero default budget: on slots that use it, any nonzero time overruns, nothing forgives
      '{2'd2, '{OP_REPORT, 2'd3, 1'b0, 32'd0}, 1'b0, BLANK_RSP},
      '{2'd2, '{OP_REPORT, 2'd3, 1'b0, 32'd1}, 1'b0, BLANK_RSP},
      '{2'd2, '{OP_REPORT, 2'd0, 1'b0, 32'd1}, 1'b1,
        '{ST_OVER_BUDGET, 1'b1, 32'd1, 7'd0, 4'd1, 32'd1, 32'd1}},
      '{2'd2, '{OP_REPORT, 2'd1, 1'b0, 32'h8000_0001}, 1'b0, BLANK_RSP}
   };

   slot_execution_budget_monitor i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Mirror a register write into the predictor; spare indexes are dropped.
   function automatic void mirror_register(input logic [2:0] index, input logic [31:0] value);
      case (index)
         CSR_ENABLE_MASK:    enabled_slots   = value[3:0];
         CSR_DEFAULT_BUDGET: fallback_budget = value;
         CSR_BUDGET_SLOT0:   slot_budgets[0] = value;
         CSR_BUDGET_SLOT1:   slot_budgets[1] = value;
         CSR_BUDGET_SLOT2:   slot_budgets[2] = value;
         CSR_BUDGET_SLOT3:   slot_budgets[3] = value;
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] effective_budget(input logic [1:0] slot);
      return (slot_budgets[slot] != 32'd0) ? slot_budgets[slot] : fallback_budget;
   endfunction

   // Update the slot record for one transaction and return the result it must give.
   function automatic rsp_type predict_outcome(input req_type item);
      record_type  rec;
      rsp_type     res;
      logic [31:0] limit;
      status_type  verdict;
      rec     = slot_records[item.slot];
      limit   = effective_budget(item.slot);
      verdict = ST_SKIPPED;
      if (item.operation == OP_CLEAR) begin
         rec     = '0;
         verdict = ST_CLEARED;
      end else if (enabled_slots[item.slot] && !rec.slot_faulted) begin
         if (item.call_failed) begin
            rec.error_counter = rec.error_counter + 7'd1;
            if (rec.error_counter >= ERROR_LIMIT) begin
               rec.error_counter = ERROR_LIMIT;
               rec.slot_faulted  = 1'b1;
               verdict           = ST_STOP_ERRORS;
            end else begin
               verdict = ST_CALL_ERROR;
            end
         end else begin
            rec.frame_counter = rec.frame_counter + 32'd1;
            rec.total_time    = rec.total_time + item.exec_time_us;
            if (item.exec_time_us > rec.longest_time) rec.longest_time = item.exec_time_us;
            if (item.exec_time_us > limit) begin
               rec.overrun_counter = rec.overrun_counter + 4'd1;
               if (rec.overrun_counter >= OVERRUN_LIMIT) begin
                  rec.overrun_counter = OVERRUN_LIMIT;
                  rec.slot_faulted    = 1'b1;
                  verdict             = ST_STOP_BUDGET;
               end else begin
                  verdict = ST_OVER_BUDGET;
               end
            end else begin
               // a frame well inside the budget forgives every earlier overrun
               if (item.exec_time_us < (limit >> 1)) rec.overrun_counter = '0;
               verdict = ST_OK;
            end
         end
      end
      slot_records[item.slot] = rec;
      res.status         = verdict;
      res.forward_events = (verdict == ST_OK) || (verdict == ST_OVER_BUDGET);
      res.frames_done    = rec.frame_counter;
      res.errors_seen    = rec.error_counter;
      res.overrun_count  = rec.overrun_counter;
      res.worst_time     = rec.longest_time;
      res.time_sum       = rec.total_time;
      return res;
   endfunction

   // Pick an elapsed time near the interesting points of the slot's budget.
   function automatic logic [31:0] pick_elapsed(input logic [1:0] slot, input int bias);
      logic [31:0] limit;
      logic [31:0] half;
      limit = effective_budget(slot);
      half  = limit >> 1;
      if (bias == TIME_OVER) return limit + 32'd1 + 32'($urandom_range(1000));
      if (bias == TIME_SHORT) return (half == 32'd0) ? 32'd0 : 32'($urandom_range(half - 32'd1));
      case ($urandom_range(7))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return limit;
         3:       return limit + 32'd1;
         4:       return half;
         5:       return half - 32'd1;
         6:       return $urandom;
         default: return $urandom_range(limit);
      endcase
   endfunction

   function automatic logic [31:0] draw_budget();
      case ($urandom_range(4))
         0:       return 32'd1;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom;
         default: return $urandom_range(20, 20000);
      endcase
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   // Present one transaction, hold it until taken, then queue its expected result.
   task automatic send_transaction(input req_type item, input logic typed, input rsp_type want,
                                   output status_type verdict);
      rsp_type predicted;
      req_item <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_outcome(item);
      expected_results.push_back(typed ? want : predicted);
      verdict = predicted.status;
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and wait for every outstanding result.
   task automatic settle();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      mirror_register(index, value);
   endtask

   task automatic apply_setting(input budget_setting_type cfg);
      write_register(CSR_ENABLE_MASK, {28'd0, cfg.mask});
      write_register(CSR_DEFAULT_BUDGET, cfg.fallback);
      write_register(CSR_BUDGET_SLOT0, cfg.budgets[0]);
      write_register(CSR_BUDGET_SLOT1, cfg.budgets[1]);
      write_register(CSR_BUDGET_SLOT2, cfg.budgets[2]);
      write_register(CSR_BUDGET_SLOT3, cfg.budgets[3]);
      write_register(CSR_SPARE_LO, $urandom);
      write_register(CSR_SPARE_HI, $urandom);
      csr_write <= 1'b0;
   endtask

   // Send one random transaction; every transaction counts toward the phase.
   task automatic issue_random(input req_type item, input int idle_chance);
      status_type verdict;
      send_transaction(item, 1'b0, BLANK_RSP, verdict);
      phase_sent++;
      if (idle_chance != 0 && $urandom_range(99) < idle_chance) hold_off($urandom_range(1, 4));
   endtask

   task automatic run_random_phase(input int idle_chance);
      int         mode;
      int         pick;
      int         len;
      logic [1:0] slot;
      req_type    item;
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
         mode = $urandom_range(99);
         slot = 2'($urandom_range(3));
         if (mode < 35) begin
            // overrun storm on one slot: mostly late frames, now and then a short one
            len = $urandom_range(8, 20);
            repeat (len) begin
               pick = $urandom_range(99);
               item.operation    = OP_REPORT;
               item.slot         = slot;
               item.call_failed  = (pick < 4);
               item.exec_time_us = pick_elapsed(slot, (pick < 88) ? TIME_OVER : TIME_SHORT);
               issue_random(item, idle_chance);
            end
         end else if (mode < 55) begin
            // error storm: long enough runs push a slot to its error fault
            len = $urandom_range(20, 110);
            repeat (len) begin
               item.operation    = OP_REPORT;
               item.slot         = slot;
               item.call_failed  = ($urandom_range(99) < 90);
               item.exec_time_us = pick_elapsed(slot, TIME_ANY);
               issue_random(item, idle_chance);
            end
         end else if (mode < 90) begin
            // noise: any slot, any flag, the odd clear
            len = $urandom_range(5, 20);
            repeat (len) begin
               item.slot         = 2'($urandom_range(3));
               item.operation    = ($urandom_range(11) == 0) ? OP_CLEAR : OP_REPORT;
               item.call_failed  = 1'($urandom_range(1));
               item.exec_time_us = pick_elapsed(item.slot, TIME_ANY);
               issue_random(item, idle_chance);
            end
         end else begin
            // clear a slot, then bring it back to life
            item.operation    = OP_CLEAR;
            item.slot         = slot;
            item.call_failed  = 1'($urandom_range(1));
            item.exec_time_us = $urandom;
            issue_random(item, idle_chance);
            len = $urandom_range(3, 8);
            repeat (len) begin
               item.operation    = OP_REPORT;
               item.call_failed  = ($urandom_range(99) < 20);
               item.exec_time_us = pick_elapsed(slot, TIME_ANY);
               issue_random(item, idle_chance);
            end
         end
      end
   endtask

   // Score every result strobe against the oldest expectation.
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result expected none actual %0h", $time, rsp_item);
         end else begin
            want = expected_results.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_item.status));
            compare_field("forward_events", 32'(want.forward_events),
                          32'(rsp_item.forward_events));
            compare_field("frames_done", want.frames_done, rsp_item.frames_done);
            compare_field("errors_seen", 32'(want.errors_seen), 32'(rsp_item.errors_seen));
            compare_field("overrun_count", 32'(want.overrun_count),
                          32'(rsp_item.overrun_count));
            compare_field("worst_time", want.worst_time, rsp_item.worst_time);
            compare_field("time_sum", want.time_sum, rsp_item.time_sum);
         end
      end
   end

   // Abandon the run once nothing has moved for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid || csr_write) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      budget_setting_type setting;
      status_type         verdict;
      logic [1:0]         active_setting;
      int                 idle_chance;

      // predictor starts from the reset state
      enabled_slots   = '0;
      fallback_budget = DEFAULT_BUDGET_RESET;
      for (int s = 0; s < 4; s++) slot_budgets[s] = '0;
      for (int s = 0; s < SLOT_COUNT; s++) slot_records[s] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table; change the setting only once the block has gone quiet
      active_setting = 2'd0;
      for (int i = 0; i < 19; i++) begin
         if (directed_rows[i].setting != active_setting) begin
            settle();
            apply_setting(directed_settings[directed_rows[i].setting]);
            active_setting = directed_rows[i].setting;
         end
         send_transaction(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want,
                          verdict);
      end

      // random phases: two fixed extreme settings, then drawn ones
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         if (p == 0) begin
            setting = '{4'hF, 32'd0, '{32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF}};
         end else if (p == 1) begin
            setting = '{4'hF, 32'hFFFF_FFFF, '{32'd1, 32'd0, 32'd100, 32'd0}};
         end else begin
            setting.mask     = ($urandom_range(2) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
            setting.fallback = draw_budget();
            for (int k = 0; k < 4; k++)
               setting.budgets[k] = ($urandom_range(1) == 0) ? 32'd0 : draw_budget();
         end
         apply_setting(setting);
         case ($urandom_range(2))
            0:       idle_chance = 0;
            1:       idle_chance = 15;
            default: idle_chance = 40;
         endcase
         // hold start high throughout the last phase
         if (p == RANDOM_PHASES - 1) idle_chance = 0;
         run_random_phase(idle_chance);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== slot_execution_budget_monitor.f =====
+incdir+design
design/sebm_pkg.sv
design/sebm_slot_update.sv
design/slot_execution_budget_monitor.sv
verif/slot_execution_budget_monitor_tb.sv
